// ===== rtl/jfd_pkg.sv =====
package jfd_pkg;

  // Largest frame counts the hardware will ever accept, whatever the limit registers say.
  localparam logic [7:0] MAX_AXIS_LIMIT   = 8'd16;
  localparam logic [7:0] MAX_BUTTON_LIMIT = 8'd64;

  localparam logic [7:0]  START_BYTE_0 = 8'hAA;
  localparam logic [7:0]  START_BYTE_1 = 8'h55;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  localparam logic [15:0] AXIS_MOST_NEG    = 16'h8000;
  localparam logic [15:0] AXIS_CLAMPED_NEG = 16'h8001;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_LIMIT   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_LIMIT = 8'd1;

  typedef enum logic [2:0] {
    PH_HUNT_AA = 3'd0,
    PH_HUNT_55 = 3'd1,
    PH_AXCNT   = 3'd2,
    PH_AXLO    = 3'd3,
    PH_AXHI    = 3'd4,
    PH_BTNCNT  = 3'd5,
    PH_BTN     = 3'd6,
    PH_CRC     = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_AXIS       = 3'd0,
    KIND_BUTTON     = 3'd1,
    KIND_GOOD       = 3'd2,
    KIND_BAD_AXCNT  = 3'd3,
    KIND_BAD_BTNCNT = 3'd4,
    KIND_CRC_ERR    = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [5:0]         item_index;
    logic signed [15:0] axis_value;
    logic               button_pressed;
    logic [4:0]         axis_total;
    logic [6:0]         button_total;
  } result_t;

endpackage

// ===== rtl/jfd_crc16_step.sv =====
module jfd_crc16_step (
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);
  import jfd_pkg::*;

  // Reflected CRC16 update, one bit per step over the incoming byte.
  always_comb begin
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_next = c;
  end

endmodule

// ===== rtl/jfd_parser.sv =====
module jfd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  input  logic [4:0]      axis_limit,
  input  logic [6:0]      button_limit,
  output logic            res_valid,
  output jfd_pkg::result_t res
);
  import jfd_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] crc, crc_next;
  logic [4:0]  axis_count, axis_count_next;
  logic [6:0]  button_count, button_count_next;
  logic [6:0]  elem, elem_next;
  logic [7:0]  held_low, held_low_next;

  logic [15:0] crc_fed;
  logic [7:0]  axis_lim;
  logic [7:0]  button_lim;
  logic [6:0]  elem_inc;
  logic [15:0] raw_axis;
  phase_t      hunt_phase;

  jfd_crc16_step u_crc (
    .crc      (crc),
    .data     (rx_byte),
    .crc_next (crc_fed)
  );

  always_comb begin
    axis_lim   = ({3'b000, axis_limit} < MAX_AXIS_LIMIT) ? {3'b000, axis_limit}
                                                         : MAX_AXIS_LIMIT;
    button_lim = ({1'b0, button_limit} < MAX_BUTTON_LIMIT) ? {1'b0, button_limit}
                                                           : MAX_BUTTON_LIMIT;
    elem_inc   = elem + 7'd1;
    raw_axis   = {rx_byte, held_low};
    hunt_phase = (rx_byte == START_BYTE_0) ? PH_HUNT_55 : PH_HUNT_AA;
  end

  always_comb begin
    phase_next        = phase;
    crc_next          = crc;
    axis_count_next   = axis_count;
    button_count_next = button_count;
    elem_next         = elem;
    held_low_next     = held_low;
    res_valid         = 1'b0;
    res               = '0;

    unique case (phase)
      PH_HUNT_AA: begin
        phase_next = hunt_phase;
      end
      PH_HUNT_55: begin
        if (rx_byte == START_BYTE_1) begin
          phase_next = PH_AXCNT;
          crc_next   = CRC_INIT;
        end else begin
          phase_next = hunt_phase;
        end
      end
      PH_AXCNT: begin
        if (rx_byte == 8'd0 || rx_byte > axis_lim) begin
          // The rejected count byte is rescanned as a possible start byte.
          phase_next = hunt_phase;
          res_valid  = 1'b1;
          res.kind   = KIND_BAD_AXCNT;
        end else begin
          crc_next        = crc_fed;
          axis_count_next = rx_byte[4:0];
          elem_next       = '0;
          phase_next      = PH_AXLO;
        end
      end
      PH_AXLO: begin
        crc_next      = crc_fed;
        held_low_next = rx_byte;
        phase_next    = PH_AXHI;
      end
      PH_AXHI: begin
        crc_next   = crc_fed;
        elem_next  = elem_inc;
        phase_next = (elem_inc >= {2'b00, axis_count}) ? PH_BTNCNT : PH_AXLO;
        res_valid      = 1'b1;
        res.kind       = KIND_AXIS;
        res.item_index = elem[5:0];
        // The most negative code has no positive twin, so it folds to -32767.
        res.axis_value = (raw_axis == AXIS_MOST_NEG) ? AXIS_CLAMPED_NEG : raw_axis;
      end
      PH_BTNCNT: begin
        if (rx_byte > button_lim) begin
          phase_next     = hunt_phase;
          res_valid      = 1'b1;
          res.kind       = KIND_BAD_BTNCNT;
          res.axis_total = axis_count;
        end else begin
          crc_next          = crc_fed;
          button_count_next = rx_byte[6:0];
          elem_next         = '0;
          phase_next        = (rx_byte == 8'd0) ? PH_CRC : PH_BTN;
        end
      end
      PH_BTN: begin
        crc_next  = crc_fed;
        elem_next = elem_inc;
        if (elem_inc >= button_count) begin
          phase_next = PH_CRC;
          elem_next  = '0;
        end
        res_valid          = 1'b1;
        res.kind           = KIND_BUTTON;
        res.item_index     = elem[5:0];
        res.button_pressed = (rx_byte != 8'd0);
      end
      PH_CRC: begin
        if (elem == 7'd0) begin
          held_low_next = rx_byte;
          elem_next     = 7'd1;
        end else begin
          elem_next        = '0;
          phase_next       = PH_HUNT_AA;
          res_valid        = 1'b1;
          res.kind         = ({rx_byte, held_low} == crc) ? KIND_GOOD : KIND_CRC_ERR;
          res.axis_total   = axis_count;
          res.button_total = button_count;
        end
      end
      default: begin
        phase_next = PH_HUNT_AA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT_AA;
      crc          <= CRC_INIT;
      axis_count   <= '0;
      button_count <= '0;
      elem         <= '0;
      held_low     <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      crc          <= crc_next;
      axis_count   <= axis_count_next;
      button_count <= button_count_next;
      elem         <= elem_next;
      held_low     <= held_low_next;
    end
  end

endmodule

// ===== rtl/jfd_out_reg.sv =====
module jfd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  jfd_pkg::result_t  din,
  input  logic              take,
  output logic              valid,
  output jfd_pkg::result_t  dout
);
  import jfd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

// ===== rtl/joystick_frame_deframer_crc16_core.sv =====
// Byte-stream deframer for joystick frames protected by CRC16-Modbus. Each
// received byte arrives as one transaction on the s_axis side. The core hunts
// for the start pair 0xAA 0x55, then parses the axis count, little-endian
// int16 axis samples, the button count, the button bytes and a little-endian
// CRC16-Modbus (init 0xFFFF, reflected polynomial 0xA001) over every byte between
// the start pair and the CRC. Each axis is reported when its high byte arrives
// (clamped to -32767..32767, meaning value/32767), and each button when its byte
// arrives. A frame closes with one report: good, bad axis count, bad button count
// or CRC mismatch. A bad count restarts the hunt at that same byte; a CRC
// mismatch restarts it at the next byte. One byte is taken per clock cycle while
// input is not stalled: the parser state, the byte-wide CRC update and the result
// are all computed combinationally between the parser registers and the output
// register, so a report appears on m_axis in the cycle after its byte is accepted.
// Input is stalled only while a report sits in the output register and the master
// side is not ready.
module joystick_frame_deframer_crc16_core (
  input  logic                          clk,
  input  logic                          rst,

  // Received bytes. tdata: rx_byte [7:0].
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,

  // Parser reports. tuser: kind [2:0].
  // tdata: item_index [5:0], axis_value [21:6], button_pressed [22],
  //        axis_total [27:23], button_total [34:28], zero fill [39:35].
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,
  output logic [2:0]                    m_axis_tuser,

  // Register writes: index 0 axis_limit, index 1 button_limit.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [jfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import jfd_pkg::*;

  logic [4:0] axis_limit;
  logic [6:0] button_limit;

  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Register writes are always accepted; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_limit   <= 5'd16;
      button_limit <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_AXIS_LIMIT) begin
        axis_limit <= cfg_data[4:0];
      end else if (cfg_index == REG_BUTTON_LIMIT) begin
        button_limit <= cfg_data[6:0];
      end
    end
  end

  // A new byte is taken whenever the output register is empty or being drained.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  jfd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .rx_byte      (s_axis_tdata),
    .axis_limit   (axis_limit),
    .button_limit (button_limit),
    .res_valid    (res_valid),
    .res          (res)
  );

  jfd_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (in_accept && res_valid),
    .din   (res),
    .take  (m_axis_tready),
    .valid (m_axis_tvalid),
    .dout  (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {5'b00000,
                         out_res.button_total,
                         out_res.axis_total,
                         out_res.button_pressed,
                         out_res.axis_value,
                         out_res.item_index};

endmodule
